// ===== design/stt_pkg.sv =====
`timescale 1ns / 1ps
package stt_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int TICK_WIDTH = 32;

  // Fixed field widths
  localparam int REQ_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;
  localparam int KIND_W   = 2;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  // Overdue distances below this count as expired (half range, rounded down)
  localparam logic [TICK_WIDTH-1:0] EXPIRE_LIMIT = {1'b0, {(TICK_WIDTH-1){1'b1}}};

  localparam logic STAT_OK         = 1'b0;
  localparam logic STAT_NOT_ACTIVE = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT     = 3'd0,
    REQ_START    = 3'd1,
    REQ_STOP     = 3'd2,
    REQ_SET_PER  = 3'd3,
    REQ_ONESHOT  = 3'd4,
    REQ_PERIODIC = 3'd5,
    REQ_READ_PER = 3'd6,
    REQ_TICK     = 3'd7
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    RESP_STATUS = 2'd0,
    RESP_EXPIRY = 2'd1,
    RESP_PERIOD = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_mode_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_DEACT,
    UPD_ARM
  } upd_op_t;

  // Sort key of one expiry candidate; larger key fires first
  typedef struct packed {
    logic                  valid;
    logic [TICK_WIDTH-1:0] od;
    logic [RANK_W-1:0]     rank;
    logic [IDX_W-1:0]      idx;
  } key_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       phase;
  } cell_ctrl_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic                status;
    logic [PERIOD_W-1:0] period;
    logic                last;
  } resp_t;

  function automatic logic key_gt(input key_t a, input key_t b);
    key_gt = {a.valid, a.od, a.rank} > {b.valid, b.od, b.rank};
  endfunction

endpackage

// ===== design/stt_req_if.sv =====
`timescale 1ns / 1ps
interface stt_req_if;
  import stt_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SLOT_W-1:0]   slot_index;
  logic [PERIOD_W-1:0] period_value;
  logic                periodic_mode;

  modport source (output valid, req_type, slot_index, period_value, periodic_mode,
                  input ready);
  modport sink (input valid, req_type, slot_index, period_value, periodic_mode,
                output ready);
endinterface

// ===== design/stt_resp_if.sv =====
`timescale 1ns / 1ps
interface stt_resp_if;
  import stt_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   resp_kind;
  logic [SLOT_W-1:0]   slot_out;
  logic                status_code;
  logic [PERIOD_W-1:0] read_period;
  logic                last_item;

  modport source (output valid, resp_kind, slot_out, status_code, read_period, last_item,
                  input ready);
  modport sink (input valid, resp_kind, slot_out, status_code, read_period, last_item,
                output ready);
endinterface

// ===== design/software_timer_table.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Fields
// req     | in  | req_type, slot_index, period_value, periodic_mode
// resp    | out | resp_kind, slot_out, status_code, read_period, last_item
//
// Control requests complete in the idle state; the status item sits in the output register.
// A tick loads every slot's key into a row of NUM_SLOTS cells, sorts them by
// odd-even exchange, then shifts out one expiry per cycle while resp is not
// stalled, and returns to idle once no expired key is left at the head.
// Synchronous reset clears the tick count, resp.valid and all slots bar deadlines.
// A stall on resp holds the emit sequence; req waits for idle and a free output.
module software_timer_table (
  input  logic       clk,
  input  logic       rst,
  stt_req_if.sink    req,
  stt_resp_if.source resp
);
  import stt_pkg::*;

  logic [TICK_WIDTH-1:0] tick_count;
  logic                  active   [NUM_SLOTS];
  logic                  periodic [NUM_SLOTS];
  logic [PERIOD_W-1:0]   period   [NUM_SLOTS];
  logic [TICK_WIDTH-1:0] deadline [NUM_SLOTS];
  logic [RANK_W-1:0]     rank     [NUM_SLOTS];

  logic                  active_upd [NUM_SLOTS];
  logic [RANK_W-1:0]     rank_upd   [NUM_SLOTS];

  state_t     state, state_next;
  logic [CNT_W-1:0] cnt;
  cell_ctrl_t cctrl;
  upd_op_t    upd_op;
  logic [IDX_W-1:0] upd_slot;

  resp_t resp_q, resp_d;
  logic  resp_valid, resp_load;

  key_t load_key [NUM_SLOTS];
  key_t cell_key [NUM_SLOTS];
  key_t head, head_next;

  logic req_fire, out_free, slot_ok, emit;
  logic [IDX_W-1:0] req_slot;
  logic [TICK_WIDTH-1:0] tick_inc;

  assign out_free  = !resp_valid || resp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign slot_ok   = 32'(req.slot_index) < NUM_SLOTS;
  assign req_slot  = IDX_W'(req.slot_index);
  assign tick_inc  = tick_count + TICK_WIDTH'(1);

  // Keys seen after the tick count advances; idle slots get a zero distance
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      load_key[i].od    = active[i] ? tick_inc - deadline[i] : '0;
      load_key[i].valid = active[i] && (load_key[i].od < EXPIRE_LIMIT);
      load_key[i].rank  = rank[i];
      load_key[i].idx   = IDX_W'(i);
    end
  end

  // Row of sort cells; the ends see keys that never swap in
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    key_t lk, rk;
    if (g == 0) begin : g_l
      assign lk = '1;
    end else begin : g_l
      assign lk = cell_key[g-1];
    end
    if (g == NUM_SLOTS - 1) begin : g_r
      assign rk = '0;
    end else begin : g_r
      assign rk = cell_key[g+1];
    end
    stt_cell u_cell (
      .clk      (clk),
      .ctrl     (cctrl),
      .pos_odd  (1'(g % 2)),
      .load_key (load_key[g]),
      .left_key (lk),
      .right_key(rk),
      .key      (cell_key[g])
    );
  end

  assign head = cell_key[0];
  assign head_next = g_cell[0].rk;

  // FSM next state, cell control and slot update selection
  always_comb begin
    state_next  = state;
    cctrl.mode  = CELL_HOLD;
    cctrl.phase = cnt[0];
    upd_op      = UPD_NONE;
    upd_slot    = req_slot;
    emit        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.req_type == REQ_TICK) begin
            cctrl.mode = CELL_LOAD;
            state_next = ST_SORT;
          end else if (slot_ok) begin
            case (req.req_type)
              REQ_INIT:  upd_op = UPD_DEACT;
              REQ_START: upd_op = UPD_ARM;
              REQ_STOP:  upd_op = UPD_DEACT;
              default:   upd_op = UPD_NONE;
            endcase
          end
        end
      end
      ST_SORT: begin
        cctrl.mode = CELL_SORT;
        if (cnt == CNT_W'(NUM_SLOTS - 1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!head.valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          emit       = 1'b1;
          cctrl.mode = CELL_SHIFT;
          upd_slot   = head.idx;
          upd_op     = periodic[head.idx] ? UPD_ARM : UPD_DEACT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Rank bookkeeping for stopping or (re)starting one slot
  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      active_upd[j] = active[j];
      rank_upd[j]   = rank[j];
      if (IDX_W'(j) == upd_slot) begin
        if (upd_op == UPD_DEACT) active_upd[j] = 1'b0;
        if (upd_op == UPD_ARM) begin
          active_upd[j] = 1'b1;
          rank_upd[j]   = '0;
        end
      end else if (active[j]) begin
        if (upd_op == UPD_DEACT && active[upd_slot] && rank[j] > rank[upd_slot])
          rank_upd[j] = rank[j] - RANK_W'(1);
        if (upd_op == UPD_ARM && !(active[upd_slot] && rank[j] > rank[upd_slot]))
          rank_upd[j] = rank[j] + RANK_W'(1);
      end
    end
  end

  // Result item selection
  always_comb begin
    resp_load   = 1'b0;
    resp_d.kind = RESP_STATUS;
    resp_d.slot = req.slot_index;
    resp_d.status = STAT_OK;
    resp_d.period = '0;
    resp_d.last   = 1'b1;
    if (emit) begin
      resp_load   = 1'b1;
      resp_d.kind = RESP_EXPIRY;
      resp_d.slot = SLOT_W'(head.idx);
      resp_d.last = !head_next.valid;
    end else if (state == ST_IDLE && req_fire && req.req_type != REQ_TICK) begin
      resp_load = 1'b1;
      if (!slot_ok) begin
        resp_d.status = STAT_NOT_ACTIVE;
      end else if (req.req_type == REQ_STOP && !active[req_slot]) begin
        resp_d.status = STAT_NOT_ACTIVE;
      end else if (req.req_type == REQ_READ_PER) begin
        resp_d.kind   = RESP_PERIOD;
        resp_d.period = period[req_slot];
      end
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      resp_valid <= 1'b0;
      tick_count <= '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        active[j]   <= 1'b0;
        periodic[j] <= 1'b0;
        period[j]   <= '0;
        rank[j]     <= '0;
      end
    end else begin
      state <= state_next;
      cnt   <= (state == ST_SORT) ? cnt + CNT_W'(1) : '0;
      if (resp_load)       resp_valid <= 1'b1;
      else if (resp.ready) resp_valid <= 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        active[j] <= active_upd[j];
        rank[j]   <= rank_upd[j];
      end
      if (state == ST_IDLE && req_fire) begin
        if (req.req_type == REQ_TICK) begin
          tick_count <= tick_inc;
        end else if (slot_ok) begin
          case (req.req_type)
            REQ_INIT: begin
              periodic[req_slot] <= req.periodic_mode;
              period[req_slot]   <= req.period_value;
            end
            REQ_SET_PER:  period[req_slot]   <= req.period_value;
            REQ_ONESHOT:  periodic[req_slot] <= 1'b0;
            REQ_PERIODIC: periodic[req_slot] <= 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (resp_load) resp_q <= resp_d;
    if (upd_op == UPD_ARM)
      deadline[upd_slot] <= tick_count + TICK_WIDTH'(period[upd_slot]);
    else if (state == ST_IDLE && req_fire && slot_ok && req.req_type == REQ_INIT)
      deadline[req_slot] <= '0;
  end

  assign resp.valid       = resp_valid;
  assign resp.resp_kind   = resp_q.kind;
  assign resp.slot_out    = resp_q.slot;
  assign resp.status_code = resp_q.status;
  assign resp.read_period = resp_q.period;
  assign resp.last_item   = resp_q.last;
endmodule

// ===== design/stt_cell.sv =====
`timescale 1ns / 1ps
module stt_cell (
  input  logic               clk,
  input  stt_pkg::cell_ctrl_t ctrl,
  input  logic               pos_odd,
  input  stt_pkg::key_t      load_key,
  input  stt_pkg::key_t      left_key,
  input  stt_pkg::key_t      right_key,
  output stt_pkg::key_t      key
);
  import stt_pkg::*;

  key_t key_q;
  logic left_of_pair;

  // In each phase a cell pairs with its right or its left neighbor
  assign left_of_pair = (pos_odd == ctrl.phase);

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CELL_LOAD:  key_q <= load_key;
      CELL_SORT: begin
        if (left_of_pair) begin
          key_q <= key_gt(right_key, key_q) ? right_key : key_q;
        end else begin
          key_q <= key_gt(left_key, key_q) ? key_q : left_key;
        end
      end
      CELL_SHIFT: key_q <= right_key;
      default:    key_q <= key_q;
    endcase
  end

  assign key = key_q;
endmodule

// ===== design/stt_checker.sv =====
`timescale 1ns / 1ps
module stt_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic [2:0]           req_type,
  input logic                 resp_valid,
  input logic                 resp_ready,
  input logic [1:0]           resp_kind,
  input logic                 status_code,
  input logic [31:0]          read_period,
  input logic                 last_item
);
  import stt_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp_kind) && $stable(last_item))
    else $error("stalled result changed");

  // Control request answers with one final item next cycle
  a_ctrl: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type != REQ_TICK |=> resp_valid && last_item)
    else $error("control request not answered");

  // Expiry items carry no status or period
  a_exp: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_kind == RESP_EXPIRY |-> status_code == STAT_OK && read_period == '0)
    else $error("bad expiry item");

  // No request taken while a result waits unconsumed
  a_free: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !resp_valid || resp_ready)
    else $error("request taken over pending result");
endmodule

bind software_timer_table stt_props u_stt_props (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_type   (req.req_type),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .resp_kind  (resp.resp_kind),
  .status_code(resp.status_code),
  .read_period(resp.read_period),
  .last_item  (resp.last_item)
);
